FILE: design/trln_pkg.sv
// Shared types and constants for the terrain lit-length block.
// Used by trln_ctrl, trln_dp and terrain_lit_length_top; depends on nothing.
`default_nettype none
package trln_pkg;

    localparam int FRAC_BITS = 12;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;          // coordinate difference
    localparam int MUL_W     = DIFF_W + 1;           // multiplier operand
    localparam int PROD_W    = 2 * MUL_W;            // multiplier result
    localparam int CROSS_W   = 2 * DIFF_W + 1;       // cross product
    localparam int NUM_W     = CROSS_W + FRAC_BITS;  // dividend and quotient
    localparam int SQ_W      = 2 * DIFF_W;           // sum of squares
    localparam int ROOT_W    = DIFF_W;               // square root
    localparam int SUM_W     = 48;
    localparam int SAT_BIT   = 70;                   // quotient limit 2^70
    localparam int CHUNK_W   = 24;                   // slice of the ratio per product
    localparam int ACC_W     = ROOT_W + 3 * CHUNK_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int MUL_STEPS = 6;
    localparam int LMUL_STEPS = 3;
    localparam int CNT_W     = 7;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_SUB,
        ST_CHECK,
        ST_ITER,
        ST_LMUL,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             latch;
        logic             prep;
        logic             mul;
        logic             lmul;
        logic [2:0]       step;
        logic             sub;
        logic             div_init;
        logic             iter;
        logic             sqrt_en;
        logic             acc;
        logic             fin;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic skip;      // first vertex, not above horizon, zero dx or zero d2x
        logic check_ok;
    } sts_t;

endpackage
`default_nettype wire

FILE: design/trln_ctrl.sv
// Controller state machine for the terrain lit-length block.
// Depends on trln_pkg; drives trln_dp through cmd_t and reads sts_t.
`default_nettype none
module trln_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire trln_pkg::sts_t  sts,
    output trln_pkg::cmd_t       cmd
);
    import trln_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_busy;

    assign out_busy = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_PREP;
            ST_PREP:  state_next = sts.skip ? ST_FIN : ST_MUL;
            ST_MUL:   if (cnt_reg == CNT_W'(MUL_STEPS)) state_next = ST_SUB;
            ST_SUB:   state_next = ST_CHECK;
            ST_CHECK: state_next = sts.check_ok ? ST_ITER : ST_FIN;
            ST_ITER:  if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_LMUL;
            ST_LMUL:  if (cnt_reg == CNT_W'(LMUL_STEPS)) state_next = ST_ACC;
            ST_ACC:   state_next = ST_FIN;
            ST_FIN:   if (!(sts.last && out_busy)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next = (state_next == state_reg) ? cnt_reg + CNT_W'(1) : '0;
    end

    always_comb begin
        cmd          = '0;
        cmd.step     = cnt_reg[2:0];
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            ST_PREP:  cmd.prep = 1'b1;
            ST_MUL:   cmd.mul = 1'b1;
            ST_SUB:   cmd.sub = 1'b1;
            ST_CHECK: cmd.div_init = 1'b1;
            ST_ITER: begin
                cmd.iter    = 1'b1;
                cmd.sqrt_en = cnt_reg < CNT_W'(SQRT_STEPS);
            end
            ST_LMUL:  cmd.lmul = 1'b1;
            ST_ACC:   cmd.acc = 1'b1;
            ST_FIN: begin
                if (!(sts.last && out_busy)) begin
                    cmd.fin      = 1'b1;
                    cmd.load_out = sts.last;
                    if (sts.last) m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/trln_dp.sv
// Datapath of the terrain lit-length block: vertex state, shared multiplier,
// radix-2 divider, bit-pair square root and the saturating sum. Uses trln_pkg.
`default_nettype none
module trln_dp (
    input  wire logic                              aclk,
    input  wire logic signed [trln_pkg::COORD_W-1:0] source_x,
    input  wire logic signed [trln_pkg::COORD_W-1:0] s_pt_x,
    input  wire logic signed [trln_pkg::COORD_W-1:0] s_pt_y,
    input  wire logic                              s_first_point,
    input  wire logic                              s_last_point,
    input  wire logic                              aresetn,
    input  wire trln_pkg::cmd_t                    cmd,
    output trln_pkg::sts_t                         sts,
    output logic [trln_pkg::SUM_W-1:0]             m_lit_length,
    output logic                                   m_saturated
);
    import trln_pkg::*;

    logic signed [COORD_W-1:0] x_reg, y_reg, prev_x_reg, prev_y_reg, hx_reg, hy_reg;
    logic                      first_reg, last_reg;
    logic signed [DIFF_W-1:0]  d1x_reg, d1y_reg, d2x_reg, ex_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SQ_W-1:0]    p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CROSS_W-1:0] dd_reg, ee_reg;
    logic [SQ_W-1:0]           v_reg;
    logic [NUM_W-1:0]          num_reg, t_reg;
    logic [CROSS_W:0]          rem_reg;
    logic [CROSS_W-1:0]        dmag_reg;
    logic [ROOT_W+1:0]         srem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [SUM_W-1:0]          sum_reg, out_len_reg;
    logic                      sat_reg, out_sat_reg;

    logic signed [MUL_W-1:0]   op_a, op_b;
    logic [CROSS_W:0]          rem_try;
    logic [ROOT_W+1:0]         srem_try, s_trial;
    logic signed [DIFF_W-1:0]  hy_ext;
    logic [CROSS_W-1:0]        emag;
    logic [ACC_W-FRAC_BITS-1:0] q;
    logic [SUM_W-1:0]          room;
    logic                      ovf, dn, en, x_neg, y_neg;

    assign hy_ext = DIFF_W'(hy_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (cmd.lmul) begin
            op_a = MUL_W'(root_reg);
            case (cmd.step)
                3'd0:    op_b = MUL_W'(t_reg[CHUNK_W-1:0]);
                3'd1:    op_b = MUL_W'(t_reg[2*CHUNK_W-1:CHUNK_W]);
                default: op_b = MUL_W'(t_reg[SAT_BIT-1:2*CHUNK_W]);
            endcase
        end else begin
            case (cmd.step)
                3'd0:    begin op_a = MUL_W'(d1x_reg); op_b = MUL_W'(hy_ext);  end
                3'd1:    begin op_a = MUL_W'(d1y_reg); op_b = MUL_W'(d2x_reg); end
                3'd2:    begin op_a = MUL_W'(ex_reg);  op_b = MUL_W'(hy_ext);  end
                3'd3:    begin op_a = MUL_W'(DIFF_W'(y_reg)); op_b = MUL_W'(d2x_reg); end
                3'd4:    begin op_a = MUL_W'(d1x_reg); op_b = MUL_W'(d1x_reg); end
                default: begin op_a = MUL_W'(d1y_reg); op_b = MUL_W'(d1y_reg); end
            endcase
        end
    end

    assign dn    = dd_reg[CROSS_W-1];
    assign en    = ee_reg[CROSS_W-1];
    assign x_neg = d1x_reg[DIFF_W-1];
    assign y_neg = d1y_reg[DIFF_W-1];
    assign emag  = en ? -ee_reg : ee_reg;

    assign sts.first = first_reg;
    assign sts.last  = last_reg;
    assign sts.skip  = first_reg || !(y_reg > hy_reg) || (x_reg == prev_x_reg)
                       || (hx_reg == source_x);
    assign sts.check_ok = (dd_reg != '0) && (ee_reg != '0)
                       && !(x_neg ^ en ^ dn)
                       && (d1y_reg != '0) && !(y_neg ^ en ^ dn)
                       && (dn ^ x_neg ^ d2x_reg[DIFF_W-1]);

    assign rem_try  = {rem_reg[CROSS_W-1:0], num_reg[NUM_W-1]};
    assign srem_try = {srem_reg[ROOT_W-1:0], v_reg[SQ_W-1:SQ_W-2]};
    assign s_trial  = {root_reg, 2'b01};

    assign q    = acc_reg[ACC_W-1:FRAC_BITS];
    assign ovf  = (t_reg[NUM_W-1:SAT_BIT] != '0) || (q[ACC_W-FRAC_BITS-1:SUM_W] != '0);
    assign room = SUM_MAX - sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            hx_reg     <= '0;
            hy_reg     <= '0;
            sum_reg    <= '0;
            sat_reg    <= 1'b0;
        end else begin
            if (cmd.acc) begin
                if (ovf || (q[SUM_W-1:0] >= room)) begin
                    sum_reg <= SUM_MAX;
                    sat_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_reg + q[SUM_W-1:0];
                end
                hx_reg <= x_reg;
                hy_reg <= y_reg;
            end
            if (cmd.fin) begin
                prev_x_reg <= x_reg;
                prev_y_reg <= y_reg;
                if (first_reg) begin
                    hx_reg  <= x_reg;
                    hy_reg  <= y_reg;
                    sum_reg <= '0;
                    sat_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            x_reg     <= s_pt_x;
            y_reg     <= s_pt_y;
            first_reg <= s_first_point;
            last_reg  <= s_last_point;
        end
        if (cmd.prep) begin
            d1x_reg <= DIFF_W'(x_reg) - DIFF_W'(prev_x_reg);
            d1y_reg <= DIFF_W'(y_reg) - DIFF_W'(prev_y_reg);
            d2x_reg <= DIFF_W'(hx_reg) - DIFF_W'(source_x);
            ex_reg  <= DIFF_W'(x_reg) - DIFF_W'(source_x);
        end
        if (cmd.mul || cmd.lmul) prod_reg <= op_a * op_b;
        if (cmd.mul) begin
            case (cmd.step)
                3'd1:    p0_reg <= prod_reg[SQ_W-1:0];
                3'd2:    p1_reg <= prod_reg[SQ_W-1:0];
                3'd3:    p2_reg <= prod_reg[SQ_W-1:0];
                3'd4:    p3_reg <= prod_reg[SQ_W-1:0];
                3'd5:    p4_reg <= prod_reg[SQ_W-1:0];
                3'd6:    p5_reg <= prod_reg[SQ_W-1:0];
                default: ;
            endcase
        end
        if (cmd.sub) begin
            dd_reg <= CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
            ee_reg <= CROSS_W'(p2_reg) - CROSS_W'(p3_reg);
            v_reg  <= p4_reg + p5_reg;
        end
        if (cmd.div_init) begin
            num_reg  <= {emag, {FRAC_BITS{1'b0}}};
            dmag_reg <= dn ? -dd_reg : dd_reg;
            rem_reg  <= '0;
            t_reg    <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.iter) begin
            num_reg <= num_reg << 1;
            if (rem_try >= {1'b0, dmag_reg}) begin
                rem_reg <= rem_try - {1'b0, dmag_reg};
                t_reg   <= {t_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_try;
                t_reg   <= {t_reg[NUM_W-2:0], 1'b0};
            end
            if (cmd.sqrt_en) begin
                v_reg <= v_reg << 2;
                if (srem_try >= s_trial) begin
                    srem_reg <= srem_try - s_trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_reg <= srem_try;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
        end
        if (cmd.lmul) begin
            case (cmd.step)
                3'd0:    acc_reg <= '0;
                3'd1:    acc_reg <= acc_reg + ACC_W'(prod_reg);
                3'd2:    acc_reg <= acc_reg + (ACC_W'(prod_reg) << CHUNK_W);
                default: acc_reg <= acc_reg + (ACC_W'(prod_reg) << (2 * CHUNK_W));
            endcase
        end
        if (cmd.load_out) begin
            out_len_reg <= first_reg ? '0 : sum_reg;
            out_sat_reg <= first_reg ? 1'b0 : sat_reg;
        end
    end

    assign m_lit_length = out_len_reg;
    assign m_saturated  = out_sat_reg;

endmodule
`default_nettype wire

FILE: design/terrain_lit_length_top.sv
// Top level of the terrain lit-length block: APB register and the
// controller/datapath pair. Depends on trln_pkg, trln_ctrl and trln_dp.
//
// Usage: vertices of a terrain polyline arrive as requests on the s_ channel
// (s_pt_x, s_pt_y in signed Q20.12, s_first_point, s_last_point). The light
// source x lives in the only register, source_x, at byte address 0 of the
// APB port; write it only while the block is idle.
// A request whose s_last_point is set produces one result on the m_ channel:
// the lit length in unsigned Q36.12 and a flag that tells the sum saturated.
// Flow: a skipped vertex (first vertex, not above the horizon, vertical
// segment, horizon above the source) goes from PREP to FIN, and one that
// fails the crossing test after six products on the shared multiplier goes
// from CHECK to FIN. A full test adds a 79-step restoring divider with the
// square root beside it, three products and the accumulate; the divider
// yields one quotient bit per cycle. The result is loaded in FIN.
// One request is in flight at a time; s_ready is high only when idle.
// The result sits in an output register, so the next request may be taken
// while it waits; if the receiver stalls, a later last vertex holds in its
// final state until the earlier result is taken. Reset clears the previous
// vertex, the horizon, the sum and its flag and source_x, and drops m_valid.
`default_nettype none
module terrain_lit_length_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic signed [trln_pkg::COORD_W-1:0] s_pt_x,
    input  wire logic signed [trln_pkg::COORD_W-1:0] s_pt_y,
    input  wire logic        s_first_point,
    input  wire logic        s_last_point,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [trln_pkg::SUM_W-1:0] m_lit_length,
    output logic             m_saturated
);
    import trln_pkg::*;

    logic signed [COORD_W-1:0] source_x_reg;
    cmd_t                      cmd;
    sts_t                      sts;

    assign pready = 1'b1;

    // Only the word at address zero exists; the low two bits are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_x_reg <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            source_x_reg <= pwdata;
        end
    end

    assign prdata = paddr[2] ? '0 : source_x_reg;

    trln_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    trln_dp u_dp (
        .aclk          (aclk),
        .source_x      (source_x_reg),
        .s_pt_x        (s_pt_x),
        .s_pt_y        (s_pt_y),
        .s_first_point (s_first_point),
        .s_last_point  (s_last_point),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .m_lit_length  (m_lit_length),
        .m_saturated   (m_saturated)
    );

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for terrain_lit_length_top: polylines are sent as
// requests, results are predicted in the bench and checked in order.
// Depends on trln_pkg and the block's RTL only.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trln_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 150;   // long enough for a tested vertex to finish
    localparam logic [2:0] ADDR_SOURCE_X = 3'd0;

    // One expected result of the m_ channel.
    typedef struct {
        logic [SUM_W-1:0] lit_length;
        logic             saturated;
    } lit_result_t;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic signed [COORD_W-1:0] s_pt_x, s_pt_y;
    logic        s_first_point, s_last_point;
    logic        m_valid, m_ready;
    logic [SUM_W-1:0] m_lit_length;
    logic        m_saturated;

    terrain_lit_length_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pt_x       (s_pt_x),
        .s_pt_y       (s_pt_y),
        .s_first_point(s_first_point),
        .s_last_point (s_last_point),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_lit_length (m_lit_length),
        .m_saturated  (m_saturated)
    );

    // Expected results, oldest first.
    lit_result_t expected_lengths[$];
    int mismatches;

    // Idling controls: percent chance per cycle of a sender gap and of a
    // receiver stall. A long hold-off forces the receiver low for a count.
    int gap_pct;
    int stall_pct;
    int hold_cycles;
    int idle_count;

    // Predictor's copy of the block's state and its register.
    logic signed [63:0] mdl_src_x;
    logic signed [63:0] mdl_prev_x, mdl_prev_y, mdl_hz_x, mdl_hz_y;
    logic [SUM_W-1:0]   mdl_sum;
    logic               mdl_sat;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int sign_of(logic signed [127:0] v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic logic [127:0] abs128(logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // Integer square root, floor, of a value below 2^128.
    function automatic logic [127:0] floor_sqrt(logic [127:0] v);
        logic [127:0] root;
        logic [127:0] cand;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= v) root = cand;
        end
        return root;
    endfunction

    // A vertex above the horizon: intersect the segment with the sight line
    // from the source through the horizon and add the visible part.
    function automatic void shade_vertex(logic signed [63:0] x, logic signed [63:0] y);
        logic signed [127:0] d1x, d1y, d2x, d2y, cross_d, cross_e;
        logic [127:0] ratio, seg_len, prod, added;
        int sd, se;
        logic over;
        d1x = x - mdl_prev_x;
        d1y = y - mdl_prev_y;
        d2x = mdl_hz_x - mdl_src_x;
        d2y = mdl_hz_y;
        if (d1x == 0 || d2x == 0) return;
        cross_d = d1x * d2y - d1y * d2x;
        if (cross_d == 0) return;
        cross_e = (x - mdl_src_x) * d2y - y * d2x;
        if (cross_e == 0) return;
        sd = (cross_d < 0) ? -1 : 1;
        se = (cross_e < 0) ? -1 : 1;
        if (sign_of(d1x) * se * sd <= 0) return;
        if (sign_of(d1y) * se * sd <= 0) return;
        if (sd * sign_of(d1x) * sign_of(d2x) >= 0) return;
        ratio   = (abs128(cross_e) << FRAC_BITS) / abs128(cross_d);
        seg_len = floor_sqrt(abs128(d1x) * abs128(d1x) + abs128(d1y) * abs128(d1y));
        over  = 1'b0;
        added = '0;
        if (ratio >= (128'd1 << SAT_BIT)) begin
            over = 1'b1;
        end else begin
            prod  = (seg_len * ratio) >> FRAC_BITS;
            if (prod > {80'd0, SUM_MAX}) over = 1'b1;
            else added = prod;
        end
        if (over || added[SUM_W-1:0] >= SUM_MAX - mdl_sum) begin
            mdl_sum = SUM_MAX;
            mdl_sat = 1'b1;
        end else begin
            mdl_sum = mdl_sum + added[SUM_W-1:0];
        end
        mdl_hz_x = x;
        mdl_hz_y = y;
    endfunction

    function automatic void predict_vertex(logic signed [COORD_W-1:0] px,
                                           logic signed [COORD_W-1:0] py,
                                           logic first, logic last);
        logic signed [63:0] x, y;
        lit_result_t res;
        x = px;
        y = py;
        if (first) begin
            mdl_hz_x = x;
            mdl_hz_y = y;
            mdl_sum  = '0;
            mdl_sat  = 1'b0;
        end else if (y > mdl_hz_y) begin
            shade_vertex(x, y);
        end
        mdl_prev_x = x;
        mdl_prev_y = y;
        if (last) begin
            res.lit_length = mdl_sum;
            res.saturated  = mdl_sat;
            expected_lengths = {expected_lengths, res};
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one vertex request; the sender may idle first. Valid stays high
    // between back-to-back requests.
    task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                               logic first, logic last);
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_pt_x        = x;
        s_pt_y        = y;
        s_first_point = first;
        s_last_point  = last;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_vertex(x, y, first, last);
    endtask

    // Waits until every expected result has come, then lets a skipped or
    // tested vertex still in flight finish.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_lengths.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write of source_x, then a read back of the same register.
    task automatic write_source_x(logic [31:0] value);
        wait_drained();
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = ADDR_SOURCE_X; pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        mdl_src_x = $signed(value);
        @(negedge aclk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== value) begin
            if (mismatches < 10)
                $display("source_x read back: expected %h, got %h", value, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
    endtask

    // Receiver: random stalls per phase, or a forced long hold-off.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles--;
        end else begin
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: each result against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_lengths.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: lit_length %h saturated %b",
                             m_lit_length, m_saturated);
                mismatches++;
            end else begin
                lit_result_t want;
                want = expected_lengths.pop_front();
                if (m_lit_length !== want.lit_length || m_saturated !== want.saturated) begin
                    if (mismatches < 10)
                        $display("mismatch: expected lit_length %h saturated %b, got %h %b",
                                 want.lit_length, want.saturated, m_lit_length, m_saturated);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no request, result or register
    // access is accepted.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("** terrain_lit_length_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    function automatic logic signed [COORD_W-1:0] rand_coord(int bits);
        logic signed [63:0] v;
        v = $signed({32'd0, $urandom}) % (64'sd1 <<< bits);
        if ($urandom_range(1)) v = -v;
        return v[COORD_W-1:0];
    endfunction

    // Directed cases: vertices before any first point, both marks together,
    // vertical segment, horizon straight above the source, parallel lines,
    // a vertex not above the horizon, coordinate extremes and a huge ratio.
    task automatic test_directed();
        // Processing from the zero state, without a first point.
        send_vertex(32'sd4096, 32'sd8192, 1'b0, 1'b0);
        send_vertex(32'sd8192, 32'sd20000, 1'b0, 1'b1);
        // Both marks at once: a fresh polyline that reports zero.
        send_vertex(32'sd100, 32'sd100, 1'b1, 1'b1);
        // Ordinary rise: source at zero, horizon left, vertex climbs.
        send_vertex(32'sd4096, 32'sd4096, 1'b1, 1'b0);
        send_vertex(32'sd8192, 32'sd2048, 1'b0, 1'b0);   // not above horizon
        send_vertex(32'sd12288, 32'sd16384, 1'b0, 1'b0);
        send_vertex(32'sd12288, 32'sd40000, 1'b0, 1'b0); // vertical segment
        send_vertex(32'sd16384, 32'sd60000, 1'b0, 1'b1);
        // Horizon straight above the source.
        send_vertex(32'sd0, 32'sd4096, 1'b1, 1'b0);
        send_vertex(32'sd4096, 32'sd9000, 1'b0, 1'b1);
        // Segment parallel to the sight line.
        send_vertex(32'sd4096, 32'sd4096, 1'b1, 1'b0);
        send_vertex(32'sd8192, 32'sd8192, 1'b0, 1'b1);
        // Coordinate extremes.
        send_vertex(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
        send_vertex(32'sd1, 32'h8000_0000, 1'b1, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0, 1'b1);
        // Nearly parallel: tiny cross product, huge ratio.
        send_vertex(32'sd1, 32'sd1, 1'b1, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0, 1'b0);
        send_vertex(32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b0, 1'b1);
        // After the last point, vertices keep accumulating.
        send_vertex(32'sd2, 32'sd5, 1'b0, 1'b0);
        send_vertex(32'sd3, 32'h7FFF_FFFF, 1'b0, 1'b1);
    endtask

    // Random polylines: mostly well-formed climbs with random content, some
    // noise requests with random marks and full-range coordinates.
    task automatic test_random_polylines(int count);
        int sent;
        int bits;
        int nverts;
        logic signed [63:0] x;
        logic signed [COORD_W-1:0] y;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 8) begin
                send_vertex($urandom, $urandom, 1'($urandom_range(1)),
                            1'($urandom_range(1)));
                sent++;
            end else begin
                bits = ($urandom_range(9) < 5) ? 16 : (($urandom_range(9) < 8) ? 24 : 31);
                nverts = $urandom_range(12, 2);
                x = rand_coord(bits);
                for (int v = 0; v < nverts; v++) begin
                    y = rand_coord(bits);
                    send_vertex(x[COORD_W-1:0], y, v == 0, v == nverts - 1);
                    case ($urandom_range(19))
                        0:       ;                                   // vertical
                        1:       x = x - $urandom_range(1 << (bits - 4));
                        default: x = x + $urandom_range(1 << (bits - 2), 1);
                    endcase
                    sent++;
                end
            end
        end
    endtask

    // The receiver holds off while polylines keep coming, so the block
    // fills and stalls its input.
    task automatic test_long_holdoff();
        hold_cycles = 600;
        for (int i = 0; i < 8; i++) begin
            send_vertex(rand_coord(16), rand_coord(16), 1'b1, 1'b0);
            send_vertex(rand_coord(16), rand_coord(16), 1'b0, 1'b1);
        end
    endtask

    // The sender pauses until every result has come, then resumes.
    task automatic test_sender_pause();
        test_random_polylines(30);
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_lengths.size() != 0) @(posedge aclk);
        test_random_polylines(30);
    endtask

    initial begin
        logic [31:0] sources[6];
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_pt_x = '0; s_pt_y = '0;
        s_first_point = 1'b0; s_last_point = 1'b0;
        m_ready = 1'b0;
        gap_pct = 0; stall_pct = 0; hold_cycles = 0; idle_count = 0;
        mismatches = 0;
        mdl_src_x = 0; mdl_prev_x = 0; mdl_prev_y = 0; mdl_hz_x = 0; mdl_hz_y = 0;
        mdl_sum = '0; mdl_sat = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        write_source_x(32'h8000_0000);
        test_directed();
        write_source_x(32'h7FFF_FFFF);
        test_directed();

        // Four idling phases, each under a different light position.
        sources = '{32'd0, 32'hFFF0_0000, 32'h0010_0000, $urandom, 32'h8000_0000, 32'h7FFF_FFFF};
        for (int ph = 0; ph < 4; ph++) begin
            write_source_x(sources[ph]);
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 45; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 45; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            test_random_polylines(380);
        end

        write_source_x(sources[4]);
        gap_pct = 0; stall_pct = 0;
        test_long_holdoff();
        write_source_x(sources[5]);
        gap_pct = 11; stall_pct = 11;
        test_sender_pause();

        wait_drained();
        if (mismatches == 0 && expected_lengths.size() == 0)
            $display("** terrain_lit_length_top: PASSED **");
        else
            $display("** terrain_lit_length_top: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
